FILE: design/tbuc_pkg.sv
// ---------------------------------------------------------------------------
// tbuc_pkg: shared types and constants of the thermal upscaler
// Frame geometry, weight constants, the channel payload types and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package tbuc_pkg;

    // Frame geometry and sample width.
    localparam int FRAME_WIDTH  = 32;
    localparam int FRAME_HEIGHT = 24;
    localparam int TEMP_BITS    = 10;

    localparam int COL_BITS = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
    localparam int ROW_BITS = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

    // Bilinear weights: step per sub-position and full scale.
    localparam int W_STEP   = 102;
    localparam int W_FULL   = 512;
    localparam int W_BITS   = 10;
    localparam int ACC_SHIFT = 18;

    // Datapath word widths.
    localparam int P_BITS = TEMP_BITS + W_BITS;
    localparam int Q_BITS = P_BITS + W_BITS;

    // Gray clamp.
    localparam int GRAY_LIMIT = 250;
    localparam int GRAY_MAX   = 255;

    // Sub-positions run 0 to SUB_LAST on each axis.
    localparam logic [2:0] SUB_LAST = 3'd4;

    typedef logic [TEMP_BITS-1:0] t_temp;
    typedef logic [COL_BITS-1:0]  t_col;
    typedef logic [ROW_BITS-1:0]  t_row;

    typedef struct packed {
        logic [9:0] temp_value;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cell_row;
        logic [4:0]  cell_col;
        logic [2:0]  sub_row;
        logic [2:0]  sub_col;
        logic [15:0] rgb565;
        logic        last_of_cell;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic       load;      // take the input item, start the line store read
        logic       capture;   // latch the upper-right corner, write the line store
        logic       issue;     // start one sub-pixel down the pipeline
        logic [2:0] sub_row;
        logic [2:0] sub_col;
        logic       last;
        logic       commit;    // shift the corners for the next pixel
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cell_done;   // the current pixel completes a cell
        logic adv;         // the pipeline moves this cycle
    } t_stat;

endpackage

FILE: design/thermal_bilinear_upscale_colormap.sv
// ---------------------------------------------------------------------------
// thermal_bilinear_upscale_colormap: 5x bilinear thermal upscaler
// Turns raster temperature pixels into false-colored RGB565 sub-pixels.
// ---------------------------------------------------------------------------
// Temperature pixels arrive one item at a time in raster order; frame_start
// restarts the position at row 0, column 0, and the position also wraps by
// itself after the last pixel of a frame. Every pixel at row 1 or later and
// column 1 or later completes the cell whose lower-right corner it is, and
// for that cell the block sends 25 result items, sub-rows outer, with
// last_of_cell set on the 25th. A completing pixel occupies the input through
// accept, line store read, 25 sub-pixel issues at one per cycle while the
// output does not stall, and corner shift; a pixel on the first row or
// column takes only accept, read and corner shift. Each sub-pixel passes
// a five-stage blend pipeline, and the next pixel is taken while the
// pipeline still drains. A stall on the output holds the whole pipeline
// and the issue.
module thermal_bilinear_upscale_colormap
    import tbuc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencing of each item.
    tbuc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and blend arithmetic.
    tbuc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

FILE: design/tbuc_ram.sv
// ---------------------------------------------------------------------------
// tbuc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module tbuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tbuc_ctrl.sv
// ---------------------------------------------------------------------------
// tbuc_ctrl: sequencing of one input item
// Accepts an item, waits for the line store read, issues the 25 sub-pixels
// of a completed cell and finally shifts the corner registers.
// ---------------------------------------------------------------------------
module tbuc_ctrl
    import tbuc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_ISSUE  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_sy, n_sy;
    logic [2:0] r_sx, n_sx;
    logic       accept;
    logic       last_sub;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign last_sub   = (r_sy == SUB_LAST) && (r_sx == SUB_LAST);

    // Commands to the datapath.
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = accept;
        o_cmd.capture = (r_state == S_READ);
        o_cmd.issue   = (r_state == S_ISSUE) && i_stat.adv;
        o_cmd.sub_row = r_sy;
        o_cmd.sub_col = r_sx;
        o_cmd.last    = last_sub;
        o_cmd.commit  = (r_state == S_COMMIT);
    end

    // Next state and sub-position counters.
    always_comb begin
        n_state = r_state;
        n_sy    = r_sy;
        n_sx    = r_sx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_sy    = '0;
                n_sx    = '0;
                n_state = i_stat.cell_done ? S_ISSUE : S_COMMIT;
            end
            S_ISSUE: begin
                if (i_stat.adv) begin
                    if (last_sub) begin
                        n_state = S_COMMIT;
                    end else if (r_sx == SUB_LAST) begin
                        n_sx = '0;
                        n_sy = r_sy + 3'd1;
                    end else begin
                        n_sx = r_sx + 3'd1;
                    end
                end
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sy    <= '0;
            r_sx    <= '0;
        end else begin
            r_state <= n_state;
            r_sy    <= n_sy;
            r_sx    <= n_sx;
        end
    end

    // An accepted item always goes to the line store read next.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted item did not start the line store read");

    // Sub-pixels are issued only while sequencing a cell.
    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_state == S_ISSUE))
        else $error("sub-pixel issued outside the issue state");

    // The last sub-pixel of a cell is followed by the corner shift.
    a_last_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && last_sub) |=> (r_state == S_COMMIT))
        else $error("corner shift did not follow the last sub-pixel");

    // Sub-position counters stay in range.
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sy <= SUB_LAST) && (r_sx <= SUB_LAST))
        else $error("sub-position counter out of range");

endmodule

FILE: design/tbuc_dpath.sv
// ---------------------------------------------------------------------------
// tbuc_dpath: position counters, line store, corners and blend pipeline
// The blend pipeline has five stages: corner products, vertical sums,
// horizontal products, gray value and false-color output register.
// ---------------------------------------------------------------------------
module tbuc_dpath
    import tbuc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    typedef struct packed {
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic [2:0] sub_row;
        logic [2:0] sub_col;
        logic       last;
    } t_tag;

    localparam t_col COL_LAST = COL_BITS'(FRAME_WIDTH - 1);
    localparam t_row ROW_LAST = ROW_BITS'(FRAME_HEIGHT - 1);

    // Weight of the far corner for sub-position s.
    function automatic logic [W_BITS-1:0] w_far(input logic [2:0] s);
        return W_BITS'(int'(s) * W_STEP);
    endfunction

    // x * 255 / 64 for a 6-bit x.
    function automatic logic [7:0] ramp(input logic [5:0] x);
        logic [13:0] prod;
        prod = {x, 8'h00} - 14'(x);
        return prod[13:6];
    endfunction

    // Four-segment false-color map, packed as RGB565.
    function automatic logic [15:0] color_map(input logic [7:0] g);
        logic [7:0] red, grn, blu;
        red = '0;
        grn = '0;
        blu = '0;
        case (g[7:6])
            2'd0: begin
                blu = ramp(g[5:0]);
            end
            2'd1: begin
                grn = ramp(g[5:0]);
                blu = ramp(~g[5:0]);
            end
            2'd2: begin
                red = ramp(g[5:0]);
                grn = 8'hFF;
            end
            2'd3: begin
                red = 8'hFF;
                grn = ramp(~g[5:0]);
            end
            default: begin
                red = '0;
            end
        endcase
        return {red[7:3], grn[7:2], blu[7:3]};
    endfunction

    // Position and corner state.
    t_col  r_col_cnt, n_col_cnt;
    t_row  r_row_cnt, n_row_cnt;
    t_col  r_col, pos_col;
    t_row  r_row, pos_row;
    t_temp r_cur, r_ur, r_al, r_left;
    t_temp ram_rdata;
    logic  adv;

    // Pipeline registers.
    logic              r_v1, r_v2, r_v3, r_v4, r_out_valid;
    t_tag              r_t1, r_t2, r_t3, r_t4;
    logic [P_BITS-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [P_BITS-1:0] r_s0, r_s1;
    logic [Q_BITS-1:0] r_q0, r_q1;
    logic [7:0]        r_gray;
    t_out_item         r_out;

    logic [W_BITS-1:0] wy1, wy0, wx1, wx0;
    logic [Q_BITS-1:0] acc;
    logic [10:0]       gray_x8;
    t_tag              tag0;

    // Position of the incoming pixel and the next counter values.
    always_comb begin
        pos_col = i_in.frame_start ? '0 : r_col_cnt;
        pos_row = i_in.frame_start ? '0 : r_row_cnt;
        n_col_cnt = pos_col + COL_BITS'(1);
        n_row_cnt = pos_row;
        if (pos_col == COL_LAST) begin
            n_col_cnt = '0;
            n_row_cnt = (pos_row == ROW_LAST) ? '0 : pos_row + ROW_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_al      <= '0;
            r_left    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
            if (i_cmd.commit) begin
                r_al   <= r_ur;
                r_left <= r_cur;
            end
        end
    end

    // Current pixel, its position and its upper-right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= t_temp'(i_in.temp_value);
            r_col <= pos_col;
            r_row <= pos_row;
        end
        if (i_cmd.capture) begin
            r_ur <= ram_rdata;
        end
    end

    // Line store holds the previous row.
    tbuc_ram #(
        .WIDTH (TEMP_BITS),
        .DEPTH (FRAME_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_re    (i_cmd.load),
        .i_raddr (pos_col),
        .o_rdata (ram_rdata)
    );

    assign o_stat.cell_done = (r_row != '0) && (r_col != '0);
    assign adv              = !r_out_valid || i_out_ready;
    assign o_stat.adv       = adv;

    // Weights for the issued row and for the column of stage three.
    always_comb begin
        wy1 = w_far(i_cmd.sub_row);
        wy0 = W_BITS'(W_FULL) - wy1;
        wx1 = w_far(r_t2.sub_col);
        wx0 = W_BITS'(W_FULL) - wx1;
        tag0.cell_row = 5'(r_row - ROW_BITS'(1));
        tag0.cell_col = 5'(r_col - COL_BITS'(1));
        tag0.sub_row  = i_cmd.sub_row;
        tag0.sub_col  = i_cmd.sub_col;
        tag0.last     = i_cmd.last;
    end

    // Blend sum, low byte scaled by eight and clamped.
    always_comb begin
        acc     = r_q0 + r_q1;
        gray_x8 = {acc[ACC_SHIFT+7:ACC_SHIFT], 3'b000};
    end

    // Pipeline valid bits; the whole pipeline holds while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= i_cmd.issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Corner products with the vertical weights.
            r_p0 <= P_BITS'(r_al)   * P_BITS'(wy0);
            r_p1 <= P_BITS'(r_left) * P_BITS'(wy1);
            r_p2 <= P_BITS'(r_ur)   * P_BITS'(wy0);
            r_p3 <= P_BITS'(r_cur)  * P_BITS'(wy1);
            r_t1 <= tag0;
            // Vertical blends of the left and right columns.
            r_s0 <= r_p0 + r_p1;
            r_s1 <= r_p2 + r_p3;
            r_t2 <= r_t1;
            // Horizontal weighting.
            r_q0 <= Q_BITS'(r_s0) * Q_BITS'(wx0);
            r_q1 <= Q_BITS'(r_s1) * Q_BITS'(wx1);
            r_t3 <= r_t2;
            // Gray value.
            r_gray <= (gray_x8 > 11'(GRAY_LIMIT)) ? 8'(GRAY_MAX) : gray_x8[7:0];
            r_t4   <= r_t3;
            // False color into the output register.
            r_out.cell_row     <= r_t4.cell_row;
            r_out.cell_col     <= r_t4.cell_col;
            r_out.sub_row      <= r_t4.sub_row;
            r_out.sub_col      <= r_t4.sub_col;
            r_out.rgb565       <= color_map(r_gray);
            r_out.last_of_cell <= r_t4.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A sub-pixel enters the pipeline only while the pipeline moves.
    a_issue_needs_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> adv)
        else $error("sub-pixel issued while the pipeline was held");

    // Valid bits shift only when the pipeline moves.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_out_valid && $stable(r_v4) && $stable(r_v1)))
        else $error("pipeline moved while the output stalled");

    // The line store is read only on an accepted pixel, written only after it.
    a_capture_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> i_cmd.capture)
        else $error("line store write did not follow the read");

endmodule

FILE: sim/thermal_bilinear_upscale_colormap_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// thermal_bilinear_upscale_colormap_tb: self-checking bench for the upscaler
// Feeds temperature frames into the block and predicts every false-colored
// sub-pixel in order. Uniform patches give fixed colors, which the directed
// table lists. Random frames and broken frames are checked against the
// bench's own bilinear and color-map model.
// Both sides of the block idle and stall at random.
// ---------------------------------------------------------------------------
module thermal_bilinear_upscale_colormap_tb
    import tbuc_pkg::*;
();

    // One directed stimulus row: a value repeated for a number of items.
    // Where has_rgb is set, every sub-pixel that the row causes must show rgb.
    typedef struct packed {
        logic [9:0]  temp;
        logic        fs;
        logic [10:0] reps;
        logic        has_rgb;
        logic [15:0] rgb;
    } t_dir_row;

    // Row 0 opens with runs of three equal values and row 1 repeats
    // them, so the second and third cell of each run have four equal corners
    // and the blend is that value exactly. The first cell of each run mixes
    // two values and is left to the predictor.
    localparam t_dir_row DIR_ROWS [15] = '{
        '{10'd0,    1'b1, 11'd3,  1'b0, 16'h0000},
        '{10'd1023, 1'b0, 11'd3,  1'b0, 16'h0000},
        '{10'd31,   1'b0, 11'd3,  1'b0, 16'h0000},
        '{10'd8,    1'b0, 11'd3,  1'b0, 16'h0000},
        '{10'd20,   1'b0, 11'd20, 1'b0, 16'h0000},
        '{10'd0,    1'b0, 11'd1,  1'b0, 16'h0000},
        '{10'd0,    1'b0, 11'd2,  1'b1, 16'h0000},
        '{10'd1023, 1'b0, 11'd1,  1'b0, 16'h0000},
        '{10'd1023, 1'b0, 11'd2,  1'b1, 16'hF800},
        '{10'd31,   1'b0, 11'd1,  1'b0, 16'h0000},
        '{10'd31,   1'b0, 11'd2,  1'b1, 16'hF8C0},
        '{10'd8,    1'b0, 11'd1,  1'b0, 16'h0000},
        '{10'd8,    1'b0, 11'd2,  1'b1, 16'h001F},
        '{10'd20,   1'b0, 11'd1,  1'b0, 16'h0000},
        '{10'd20,   1'b0, 11'd2,  1'b1, 16'h7FE0}
    };

    localparam int RANDOM_ITEMS   = 220;
    localparam int SINK_LONG_HOLD = 300;
    localparam int SETTLE_CYCLES  = 40;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_pixel;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_subpx;

    // Bench-side copy of the frame position and corner state.
    t_temp       prev_row [FRAME_WIDTH];
    t_temp       ul_corner;
    t_temp       left_corner;
    int unsigned col_pos;
    int unsigned row_pos;

    t_out_item   pending_subpx [$];
    t_out_item   want;
    int unsigned fail_count;
    bit          no_idle;
    int unsigned long_holds_asked;
    int unsigned long_holds_done;

    thermal_bilinear_upscale_colormap u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_pixel),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_subpx)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Four-segment false-color map, packed as RGB565.
    function automatic logic [15:0] false_color(input logic [7:0] g);
        int unsigned gv, r, gr, b;
        logic [7:0] r8, g8, b8;
        gv = g;
        r  = 0;
        gr = 0;
        b  = 0;
        if (gv <= 63) begin
            b = gv * 255 / 64;
        end else if (gv <= 127) begin
            gr = (gv - 64) * 255 / 64;
            b  = (127 - gv) * 255 / 64;
        end else if (gv <= 191) begin
            r  = (gv - 128) * 255 / 64;
            gr = 255;
        end else begin
            r  = 255;
            gr = (255 - gv) * 255 / 64;
        end
        r8 = r[7:0];
        g8 = gr[7:0];
        b8 = b[7:0];
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    // Works out the sub-pixels of one accepted item and updates the state.
    // A pinned color replaces the computed one for the directed rows.
    task automatic upscale_pixel(input t_in_item px, input bit pin_rgb,
                                 input logic [15:0] rgb_pin);
        t_temp       cur;
        t_temp       upper;
        int unsigned sy, sx, wy0, wy1, wx0, wx1, acc, blend, gray, n;
        t_out_item   e;
        cur = px.temp_value[TEMP_BITS-1:0];
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        upper = prev_row[col_pos];
        n = 0;
        if (row_pos >= 1 && col_pos >= 1) begin
            for (sy = 0; sy <= SUB_LAST; sy++) begin
                wy1 = sy * W_STEP;
                wy0 = W_FULL - wy1;
                for (sx = 0; sx <= SUB_LAST; sx++) begin
                    wx1 = sx * W_STEP;
                    wx0 = W_FULL - wx1;
                    acc = ul_corner * wx0 * wy0 + left_corner * wx0 * wy1
                        + upper * wx1 * wy0 + cur * wx1 * wy1;
                    blend = acc >> ACC_SHIFT;
                    gray  = blend[7:0] * 8;
                    if (gray > GRAY_LIMIT) gray = GRAY_MAX;
                    e.cell_row     = 5'(row_pos - 1);
                    e.cell_col     = 5'(col_pos - 1);
                    e.sub_row      = 3'(sy);
                    e.sub_col      = 3'(sx);
                    e.rgb565       = pin_rgb ? rgb_pin : false_color(gray[7:0]);
                    e.last_of_cell = (n == 24);
                    pending_subpx.push_back(e);
                    n++;
                end
            end
        end
        ul_corner         = upper;
        left_corner       = cur;
        prev_row[col_pos] = cur;
        col_pos++;
        if (col_pos >= FRAME_WIDTH) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= FRAME_HEIGHT) row_pos = 0;
        end
    endtask

    // Sender gap: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item after a gap and predicts it once it is accepted.
    task automatic send_pixel(input t_in_item px, input int unsigned gap,
                              input bit pin_rgb, input logic [15:0] rgb_pin);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        do @(posedge clk); while (!in_ready);
        upscale_pixel(px, pin_rgb, rgb_pin);
    endtask

    // Stops offering items until every predicted sub-pixel has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_subpx.size() != 0) @(posedge clk);
    endtask

    task automatic flag_field(input string field, input logic [15:0] exp_val,
                              input logic [15:0] got_val);
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
        fail_count++;
    endtask

    // Result checker: each accepted sub-pixel against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_subpx.size() == 0) begin
                flag_field("unexpected item rgb565", 16'h0, out_subpx.rgb565);
            end else begin
                want = pending_subpx.pop_front();
                if (out_subpx.cell_row !== want.cell_row)
                    flag_field("cell_row", 16'(want.cell_row), 16'(out_subpx.cell_row));
                if (out_subpx.cell_col !== want.cell_col)
                    flag_field("cell_col", 16'(want.cell_col), 16'(out_subpx.cell_col));
                if (out_subpx.sub_row !== want.sub_row)
                    flag_field("sub_row", 16'(want.sub_row), 16'(out_subpx.sub_row));
                if (out_subpx.sub_col !== want.sub_col)
                    flag_field("sub_col", 16'(want.sub_col), 16'(out_subpx.sub_col));
                if (out_subpx.rgb565 !== want.rgb565)
                    flag_field("rgb565", want.rgb565, out_subpx.rgb565);
                if (out_subpx.last_of_cell !== want.last_of_cell)
                    flag_field("last_of_cell", 16'(want.last_of_cell),
                               16'(out_subpx.last_of_cell));
            end
        end
    end

    // Receiver: random short and long stalls, a long hold-off on request,
    // and steady readiness during the no-idle stretch.
    initial begin : sink
        int unsigned hold_left;
        int unsigned r;
        hold_left       = 0;
        long_holds_done = 0;
        out_ready       = 1'b0;
        forever begin
            @(negedge clk);
            if (long_holds_done != long_holds_asked) begin
                long_holds_done++;
                out_ready <= 1'b0;
                repeat (SINK_LONG_HOLD) @(negedge clk);
            end else if (no_idle) begin
                out_ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    hold_left = $urandom_range(8, 40);
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= (r >= 25);
                end
            end
        end
    end

    // Stimulus: directed table, then random frames.
    initial begin : stimulus
        t_in_item    px;
        int unsigned i, k, run_len, sent;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_pixel         = '0;
        no_idle          = 1'b0;
        long_holds_asked = 0;
        fail_count       = 0;
        col_pos          = 0;
        row_pos          = 0;
        ul_corner        = '0;
        left_corner      = '0;
        foreach (prev_row[j]) prev_row[j] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows, each repeated as its count says.
        for (i = 0; i < $size(DIR_ROWS); i++) begin
            for (k = 0; k < DIR_ROWS[i].reps; k++) begin
                px.temp_value  = DIR_ROWS[i].temp;
                px.frame_start = (k == 0) ? DIR_ROWS[i].fs : 1'b0;
                send_pixel(px, pick_gap(), DIR_ROWS[i].has_rgb, DIR_ROWS[i].rgb);
            end
        end
        drain_results();

        // Random frames, mostly long enough to complete cells, some broken
        // short, with a rare stray frame start inside a run.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) run_len = $urandom_range(2, 30);
            else run_len = $urandom_range(FRAME_WIDTH + 2, 4 * FRAME_WIDTH);
            if (run_len > RANDOM_ITEMS - sent) run_len = RANDOM_ITEMS - sent;
            for (k = 0; k < run_len; k++) begin
                px.temp_value  = 10'($urandom);
                px.frame_start = (k == 0) || ($urandom_range(0, 99) == 0);
                no_idle = (sent >= 150 && sent < 190);
                // The receiver holds off long while items keep coming.
                if (sent == 80) long_holds_asked++;
                send_pixel(px, pick_gap(), 1'b0, 16'h0);
                sent++;
            end
        end
        no_idle = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin : watchdog
        #60ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
